[rtl/ssd_pkg.sv]
// shared constants and types for the segment to segment distance pipeline
package ssd_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int PFRAC           = 32;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 3;
  localparam int MUL_LAT         = 2;
  localparam logic [DATA_W-1:0] THR_RESET = DATA_W'(1);

  typedef enum logic [ADDR_W-3:0] {
    REG_THRESHOLD = '0
  } reg_idx_t;

  typedef enum logic [1:0] {
    RM_DIV  = 2'd0,
    RM_ZERO = 2'd1,
    RM_ONE  = 2'd2
  } ratio_mode_t;

endpackage

[rtl/ssd_wmul.sv]
// pipelined signed multiplier array built from four partial products per lane
module ssd_wmul #(
  parameter int AW = 68,
  parameter int BW = 68,
  parameter int N  = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a_i [N],
  input  logic signed [BW-1:0]     b_i [N],
  output logic signed [AW+BW-1:0]  p_o [N]
);

  localparam int AL  = AW / 2;
  localparam int AH  = AW - AL;
  localparam int BL  = BW / 2;
  localparam int BH  = BW - BL;
  localparam int PWD = AW + BW;
  localparam int LLW = AL + BL;
  localparam int LHW = AL + 1 + BH;
  localparam int HLW = AH + BL + 1;
  localparam int HHW = AH + BH;

  logic        [LLW-1:0] ll_r [N];
  logic signed [LHW-1:0] lh_r [N];
  logic signed [HLW-1:0] hl_r [N];
  logic signed [HHW-1:0] hh_r [N];
  logic        [LLW-1:0] ll_nxt [N];
  logic signed [LHW-1:0] lh_nxt [N];
  logic signed [HLW-1:0] hl_nxt [N];
  logic signed [HHW-1:0] hh_nxt [N];
  logic signed [PWD-1:0] p_r [N];
  logic signed [PWD-1:0] p_nxt [N];
  logic signed [PWD-1:0] ll_x [N];
  logic signed [PWD-1:0] lh_x [N];
  logic signed [PWD-1:0] hl_x [N];
  logic signed [PWD-1:0] hh_x [N];

  always_comb begin
    for (int n = 0; n < N; n++) begin
      ll_nxt[n] = a_i[n][AL-1:0] * b_i[n][BL-1:0];
      lh_nxt[n] = $signed({1'b0, a_i[n][AL-1:0]}) * $signed(b_i[n][BW-1:BL]);
      hl_nxt[n] = $signed(a_i[n][AW-1:AL]) * $signed({1'b0, b_i[n][BL-1:0]});
      hh_nxt[n] = $signed(a_i[n][AW-1:AL]) * $signed(b_i[n][BW-1:BL]);
    end
  end

  always_comb begin
    for (int n = 0; n < N; n++) begin
      ll_x[n]  = {{(PWD-LLW){1'b0}}, ll_r[n]};
      lh_x[n]  = {{(PWD-LHW){lh_r[n][LHW-1]}}, lh_r[n]};
      hl_x[n]  = {{(PWD-HLW){hl_r[n][HLW-1]}}, hl_r[n]};
      hh_x[n]  = {{(PWD-HHW){hh_r[n][HHW-1]}}, hh_r[n]};
      p_nxt[n] = (hh_x[n] <<< (AL + BL)) + (lh_x[n] <<< AL) + (hl_x[n] <<< BL) + ll_x[n];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

[rtl/ssd_div.sv]
// two-lane clamped ratio unit, one quotient bit per pipeline stage
module ssd_div #(
  parameter int NW  = 140,
  parameter int SBW = 99
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic signed [NW-1:0]         num_i [2],
  input  logic signed [NW-1:0]         den_i [2],
  input  logic signed [NW-1:0]         thr_i,
  input  logic [SBW-1:0]               side_i,
  output logic                         vld_o,
  output logic [ssd_pkg::PFRAC:0]      q_o [2],
  output logic [SBW-1:0]               side_o
);

  localparam int P   = ssd_pkg::PFRAC;
  localparam int RMW = NW - 1;

  ssd_pkg::ratio_mode_t md_r   [P+1][2];
  ssd_pkg::ratio_mode_t md_nxt [2];
  logic [RMW-1:0] rm_r   [P+1][2];
  logic [RMW-1:0] dn_r   [P+1][2];
  logic [P-1:0]   qb_r   [P+1][2];
  logic [RMW-1:0] rm_nxt [P+1][2];
  logic [P-1:0]   qb_nxt [P+1][2];
  logic [RMW:0]   r2     [P+1][2];
  logic [SBW-1:0] sd_r   [P+1];
  logic           vld_r  [P+1];
  logic signed [NW-1:0] absn [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      absn[l] = num_i[l][NW-1] ? -num_i[l] : num_i[l];
      if (absn[l] < thr_i || den_i[l][NW-1] || den_i[l] == '0 ||
          num_i[l][NW-1] || num_i[l] == '0) begin
        md_nxt[l] = ssd_pkg::RM_ZERO;
      end else if (num_i[l] >= den_i[l]) begin
        md_nxt[l] = ssd_pkg::RM_ONE;
      end else begin
        md_nxt[l] = ssd_pkg::RM_DIV;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rm_nxt[0][l] = num_i[l][RMW-1:0];
      qb_nxt[0][l] = '0;
      r2[0][l]     = '0;
    end
    for (int k = 1; k <= P; k++) begin
      for (int l = 0; l < 2; l++) begin
        r2[k][l] = {rm_r[k-1][l], 1'b0};
        if (r2[k][l] >= {1'b0, dn_r[k-1][l]}) begin
          rm_nxt[k][l] = RMW'(r2[k][l] - {1'b0, dn_r[k-1][l]});
          qb_nxt[k][l] = {qb_r[k-1][l][P-2:0], 1'b1};
        end else begin
          rm_nxt[k][l] = r2[k][l][RMW-1:0];
          qb_nxt[k][l] = {qb_r[k-1][l][P-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        md_r[0][l] <= md_nxt[l];
        dn_r[0][l] <= den_i[l][RMW-1:0];
      end
      sd_r[0] <= side_i;
      for (int k = 1; k <= P; k++) begin
        md_r[k] <= md_r[k-1];
        dn_r[k] <= dn_r[k-1];
        sd_r[k] <= sd_r[k-1];
      end
      rm_r <= rm_nxt;
      qb_r <= qb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= P; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k <= P; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      case (md_r[P][l])
        ssd_pkg::RM_ONE: q_o[l] = {1'b1, {P{1'b0}}};
        ssd_pkg::RM_DIV: q_o[l] = {1'b0, qb_r[P][l]};
        default:         q_o[l] = '0;
      endcase
    end
  end

  assign vld_o  = vld_r[P];
  assign side_o = sd_r[P];

endmodule

[rtl/ssd_sqrt.sv]
// pipelined integer square root, one root bit per stage, then round and saturate
module ssd_sqrt #(
  parameter int SW = 138,
  parameter int OW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [SW-1:0] sum_i,
  output logic          vld_o,
  output logic [OW-1:0] dist_o
);

  localparam int P  = ssd_pkg::PFRAC;
  localparam int RB = OW + P;

  logic [2*RB-1:0] x_r     [RB+1];
  logic [RB+1:0]   rem_r   [RB+1];
  logic [RB-1:0]   root_r  [RB+1];
  logic            sat_r   [RB+1];
  logic            vld_r   [RB+1];
  logic [RB+1:0]   rem_nxt [RB+1];
  logic [RB-1:0]   root_nxt[RB+1];
  logic [RB+3:0]   cand    [RB+1];
  logic [RB+3:0]   trial   [RB+1];
  logic [RB:0]     rnd;
  logic [OW-1:0]   dist_nxt;
  logic [OW-1:0]   dist_r;
  logic            vout_r;

  always_comb begin
    rem_nxt[0]  = '0;
    root_nxt[0] = '0;
    cand[0]     = '0;
    trial[0]    = '0;
    for (int k = 1; k <= RB; k++) begin
      cand[k]  = {rem_r[k-1], x_r[k-1][2*RB-1 -: 2]};
      trial[k] = {2'b00, root_r[k-1], 2'b01};
      if (cand[k] >= trial[k]) begin
        rem_nxt[k]  = (RB+2)'(cand[k] - trial[k]);
        root_nxt[k] = {root_r[k-1][RB-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cand[k][RB+1:0];
        root_nxt[k] = {root_r[k-1][RB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rnd = {1'b0, root_r[RB]} + {{(RB+1-P){1'b0}}, 1'b1, {(P-1){1'b0}}};
    if (sat_r[RB] || rnd[RB]) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = rnd[RB-1:P];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= sum_i[2*RB-1:0];
      sat_r[0]  <= |sum_i[SW-1:2*RB];
      rem_r[0]  <= rem_nxt[0];
      root_r[0] <= root_nxt[0];
      for (int k = 1; k <= RB; k++) begin
        x_r[k]    <= {x_r[k-1][2*RB-3:0], 2'b00};
        sat_r[k]  <= sat_r[k-1];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
      dist_r <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= RB; k++) begin
        vld_r[k] <= 1'b0;
      end
      vout_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k <= RB; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      vout_r <= vld_r[RB];
    end
  end

  assign vld_o  = vout_r;
  assign dist_o = dist_r;

endmodule

[rtl/segment_segment_distance.sv]
// Closest distance between two 3D segments given as signed fixed-point endpoints. One segment
// pair enters per clock and one distance leaves per clock while the pipeline is not stalled.
// The longest parts of the pipeline are the 32-stage ratio divider and the 64-stage
// bit-per-stage square root (at the default width). The whole pipeline advances together
// whenever the output register is empty or being taken. The near-zero threshold register
// sits at byte address 0 and resets to 1.
module segment_segment_distance #(
  parameter int COORD_WIDTH     = ssd_pkg::COORD_WIDTH,
  parameter int COORD_FRAC_BITS = ssd_pkg::COORD_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_WIDTH-1:0]    in_seg1_start_x,
  input  logic signed [COORD_WIDTH-1:0]    in_seg1_start_y,
  input  logic signed [COORD_WIDTH-1:0]    in_seg1_start_z,
  input  logic signed [COORD_WIDTH-1:0]    in_seg1_end_x,
  input  logic signed [COORD_WIDTH-1:0]    in_seg1_end_y,
  input  logic signed [COORD_WIDTH-1:0]    in_seg1_end_z,
  input  logic signed [COORD_WIDTH-1:0]    in_seg2_start_x,
  input  logic signed [COORD_WIDTH-1:0]    in_seg2_start_y,
  input  logic signed [COORD_WIDTH-1:0]    in_seg2_start_z,
  input  logic signed [COORD_WIDTH-1:0]    in_seg2_end_x,
  input  logic signed [COORD_WIDTH-1:0]    in_seg2_end_y,
  input  logic signed [COORD_WIDTH-1:0]    in_seg2_end_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COORD_WIDTH-1:0]           out_closest_distance,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssd_pkg::ADDR_W-1:0]       paddr,
  input  logic [ssd_pkg::DATA_W-1:0]       pwdata,
  output logic [ssd_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int C    = COORD_WIDTH;
  localparam int F    = COORD_FRAC_BITS;
  localparam int P    = ssd_pkg::PFRAC;
  localparam int TW   = ssd_pkg::DATA_W;
  localparam int ML   = ssd_pkg::MUL_LAT;
  localparam int DW   = C + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;
  localparam int NA   = 2 * DOTW + 1;
  localparam int NB   = DOTW + 2 * F + 1;
  localparam int NC   = 4 * F + 2;
  localparam int ND   = TW + 2 * F + 1;
  localparam int NAB  = (NA > NB) ? NA : NB;
  localparam int NCD  = (NC > ND) ? NC : ND;
  localparam int NW   = ((NAB > NCD) ? NAB : NCD) + 1;
  localparam int MW   = P + 2 + DW;
  localparam int CW   = MW + 1;
  localparam int SW   = 2 * CW + 2;
  localparam int SBW  = 9 * DW;

  function automatic logic signed [NW-1:0] ext_q(input logic signed [2*DOTW-1:0] x);
    return {{(NW-2*DOTW){x[2*DOTW-1]}}, x};
  endfunction

  function automatic logic signed [NW-1:0] ext_d(input logic signed [DOTW-1:0] x);
    return {{(NW-DOTW){x[DOTW-1]}}, x};
  endfunction

  logic en;
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  // configuration
  logic [TW-1:0] thr_r;
  logic [TW-1:0] thr_nxt;
  ssd_pkg::reg_idx_t reg_idx;

  assign reg_idx = ssd_pkg::reg_idx_t'(paddr[ssd_pkg::ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    thr_nxt = thr_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ssd_pkg::REG_THRESHOLD: thr_nxt = pwdata;
        default:                thr_nxt = thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ssd_pkg::REG_THRESHOLD: prdata = thr_r;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ssd_pkg::THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // pipeline registers
  logic signed [C-1:0]    pt_r  [12];
  logic signed [DW-1:0]   dv_nxt[9];
  logic signed [DW-1:0]   dv2_r [9];
  logic signed [PW-1:0]   pr_nxt[15];
  logic signed [PW-1:0]   pr3_r [15];
  logic signed [DW-1:0]   dv3_r [9];
  logic signed [DOTW-1:0] dt_nxt[5];
  logic signed [DOTW-1:0] dt4_r [5];
  logic signed [DW-1:0]   dv4_r [9];
  logic signed [DW-1:0]   dvl_r [ML][9];
  logic signed [DOTW-1:0] dtl_r [ML][5];
  logic                   vl_r  [ML];
  logic signed [DOTW-1:0] ma    [6];
  logic signed [DOTW-1:0] mb    [6];
  logic signed [2*DOTW-1:0] mp  [6];
  logic signed [NW-1:0]   dd7_r, sn7_r, tn7_r;
  logic signed [DW-1:0]   dv7_r [9];
  logic signed [DOTW-1:0] dt7_r [5];
  logic signed [NW-1:0]   b4_7, c4_7, e4_7;
  logic signed [NW-1:0]   thr4, one4;
  logic signed [NW-1:0]   sn8_nxt, sd8_nxt, tn8_nxt, td8_nxt;
  logic signed [NW-1:0]   sn8_r, sd8_r, tn8_r, td8_r;
  logic signed [DW-1:0]   dv8_r [9];
  logic signed [DOTW-1:0] dt8_r [5];
  logic signed [NW-1:0]   a4_8, b4_8, d4_8, ev;
  logic                   on_edge;
  logic signed [NW-1:0]   rn9_nxt[2];
  logic signed [NW-1:0]   rd9_nxt[2];
  logic signed [NW-1:0]   rn9_r [2];
  logic signed [NW-1:0]   rd9_r [2];
  logic signed [DW-1:0]   dv9_r [9];
  logic [SBW-1:0]         dv9_pk;
  logic                   v1_r, v2_r, v3_r, v4_r, v7_r, v8_r, v9_r;
  logic                   vd;
  logic [P:0]             qd [2];
  logic [SBW-1:0]         sd_pk;
  logic signed [DW-1:0]   dvd [9];
  logic signed [P+1:0]    sc, tc;
  logic signed [MW-1:0]   su_nxt[3];
  logic signed [MW-1:0]   tv_nxt[3];
  logic signed [MW-1:0]   su_r [3];
  logic signed [MW-1:0]   tv_r [3];
  logic signed [DW-1:0]   wc_r [3];
  logic                   vc1_r, vc2_r;
  logic signed [CW-1:0]   cp_nxt[3];
  logic signed [CW-1:0]   cp_r [3];
  logic signed [2*CW-1:0] sq [3];
  logic                   vql_r [ML];
  logic [SW-1:0]          sum_nxt;
  logic [SW-1:0]          sum_r;
  logic                   vs_r;

  // differences u, v, w
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_nxt[i]   = {pt_r[3+i][C-1], pt_r[3+i]} - {pt_r[i][C-1], pt_r[i]};
      dv_nxt[3+i] = {pt_r[9+i][C-1], pt_r[9+i]} - {pt_r[6+i][C-1], pt_r[6+i]};
      dv_nxt[6+i] = {pt_r[i][C-1], pt_r[i]} - {pt_r[6+i][C-1], pt_r[6+i]};
    end
  end

  // dot product terms a, b, c, d, e
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_nxt[i]    = dv2_r[i] * dv2_r[i];
      pr_nxt[3+i]  = dv2_r[i] * dv2_r[3+i];
      pr_nxt[6+i]  = dv2_r[3+i] * dv2_r[3+i];
      pr_nxt[9+i]  = dv2_r[i] * dv2_r[6+i];
      pr_nxt[12+i] = dv2_r[3+i] * dv2_r[6+i];
    end
    for (int k = 0; k < 5; k++) begin
      dt_nxt[k] = {{2{pr3_r[3*k][PW-1]}}, pr3_r[3*k]}
                + {{2{pr3_r[3*k+1][PW-1]}}, pr3_r[3*k+1]}
                + {{2{pr3_r[3*k+2][PW-1]}}, pr3_r[3*k+2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0]  <= in_seg1_start_x;
      pt_r[1]  <= in_seg1_start_y;
      pt_r[2]  <= in_seg1_start_z;
      pt_r[3]  <= in_seg1_end_x;
      pt_r[4]  <= in_seg1_end_y;
      pt_r[5]  <= in_seg1_end_z;
      pt_r[6]  <= in_seg2_start_x;
      pt_r[7]  <= in_seg2_start_y;
      pt_r[8]  <= in_seg2_start_z;
      pt_r[9]  <= in_seg2_end_x;
      pt_r[10] <= in_seg2_end_y;
      pt_r[11] <= in_seg2_end_z;
      dv2_r    <= dv_nxt;
      pr3_r    <= pr_nxt;
      dv3_r    <= dv2_r;
      dt4_r    <= dt_nxt;
      dv4_r    <= dv3_r;
      dvl_r[0] <= dv4_r;
      dtl_r[0] <= dt4_r;
      for (int k = 1; k < ML; k++) begin
        dvl_r[k] <= dvl_r[k-1];
        dtl_r[k] <= dtl_r[k-1];
      end
    end
  end

  // a*c, b*b, b*e, c*d, a*e, b*d
  always_comb begin
    ma[0] = dt4_r[0]; mb[0] = dt4_r[2];
    ma[1] = dt4_r[1]; mb[1] = dt4_r[1];
    ma[2] = dt4_r[1]; mb[2] = dt4_r[4];
    ma[3] = dt4_r[2]; mb[3] = dt4_r[3];
    ma[4] = dt4_r[0]; mb[4] = dt4_r[4];
    ma[5] = dt4_r[1]; mb[5] = dt4_r[3];
  end

  ssd_wmul #(.AW(DOTW), .BW(DOTW), .N(6)) u_qmul (
    .clk (clk),
    .en  (en),
    .a_i (ma),
    .b_i (mb),
    .p_o (mp)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dd7_r <= ext_q(mp[0]) - ext_q(mp[1]);
      sn7_r <= ext_q(mp[2]) - ext_q(mp[3]);
      tn7_r <= ext_q(mp[4]) - ext_q(mp[5]);
      dv7_r <= dvl_r[ML-1];
      dt7_r <= dtl_r[ML-1];
    end
  end

  // near-parallel test and s edge clamp
  always_comb begin
    b4_7 = ext_d(dt7_r[1]) <<< (2 * F);
    c4_7 = ext_d(dt7_r[2]) <<< (2 * F);
    e4_7 = ext_d(dt7_r[4]) <<< (2 * F);
    thr4 = $signed({{(NW-TW){1'b0}}, thr_r}) <<< (2 * F);
    one4 = $signed({{(NW-1){1'b0}}, 1'b1}) <<< (4 * F);
    if (dd7_r < thr4) begin
      sn8_nxt = '0;
      sd8_nxt = one4;
      tn8_nxt = e4_7;
      td8_nxt = c4_7;
    end else begin
      sn8_nxt = sn7_r;
      sd8_nxt = dd7_r;
      tn8_nxt = tn7_r;
      td8_nxt = dd7_r;
      if (sn7_r[NW-1]) begin
        sn8_nxt = '0;
        tn8_nxt = e4_7;
        td8_nxt = c4_7;
      end else if (sn7_r > dd7_r) begin
        sn8_nxt = dd7_r;
        tn8_nxt = e4_7 + b4_7;
        td8_nxt = c4_7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn8_r <= sn8_nxt;
      sd8_r <= sd8_nxt;
      tn8_r <= tn8_nxt;
      td8_r <= td8_nxt;
      dv8_r <= dv7_r;
      dt8_r <= dt7_r;
    end
  end

  // t edge clamp with s recomputed
  always_comb begin
    a4_8       = ext_d(dt8_r[0]) <<< (2 * F);
    b4_8       = ext_d(dt8_r[1]) <<< (2 * F);
    d4_8       = ext_d(dt8_r[3]) <<< (2 * F);
    rn9_nxt[0] = sn8_r;
    rd9_nxt[0] = sd8_r;
    rn9_nxt[1] = tn8_r;
    rd9_nxt[1] = td8_r;
    on_edge    = 1'b0;
    ev         = '0;
    if (tn8_r[NW-1]) begin
      rn9_nxt[1] = '0;
      on_edge    = 1'b1;
      ev         = -d4_8;
    end else if (tn8_r > td8_r) begin
      rn9_nxt[1] = td8_r;
      on_edge    = 1'b1;
      ev         = b4_8 - d4_8;
    end
    if (on_edge) begin
      if (ev[NW-1]) begin
        rn9_nxt[0] = '0;
      end else if (ev > a4_8) begin
        rn9_nxt[0] = sd8_r;
      end else begin
        rn9_nxt[0] = ev;
        rd9_nxt[0] = a4_8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn9_r <= rn9_nxt;
      rd9_r <= rd9_nxt;
      dv9_r <= dv8_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      dv9_pk[i*DW +: DW] = dv9_r[i];
    end
  end

  ssd_div #(.NW(NW), .SBW(SBW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v9_r),
    .num_i  (rn9_r),
    .den_i  (rd9_r),
    .thr_i  (thr4),
    .side_i (dv9_pk),
    .vld_o  (vd),
    .q_o    (qd),
    .side_o (sd_pk)
  );

  // closest-point difference w + sc*u - tc*v
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      dvd[i] = $signed(sd_pk[i*DW +: DW]);
    end
    sc = $signed({1'b0, qd[0]});
    tc = $signed({1'b0, qd[1]});
    for (int i = 0; i < 3; i++) begin
      su_nxt[i] = sc * dvd[i];
      tv_nxt[i] = tc * dvd[3+i];
      cp_nxt[i] = {{(CW-DW-P){wc_r[i][DW-1]}}, wc_r[i], {P{1'b0}}}
                + {{(CW-MW){su_r[i][MW-1]}}, su_r[i]}
                - {{(CW-MW){tv_r[i][MW-1]}}, tv_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_r <= su_nxt;
      tv_r <= tv_nxt;
      for (int i = 0; i < 3; i++) begin
        wc_r[i] <= dvd[6+i];
      end
      cp_r <= cp_nxt;
    end
  end

  ssd_wmul #(.AW(CW), .BW(CW), .N(3)) u_smul (
    .clk (clk),
    .en  (en),
    .a_i (cp_r),
    .b_i (cp_r),
    .p_o (sq)
  );

  assign sum_nxt = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      vc1_r <= 1'b0;
      vc2_r <= 1'b0;
      vs_r  <= 1'b0;
      for (int k = 0; k < ML; k++) begin
        vl_r[k]  <= 1'b0;
        vql_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      vl_r[0]  <= v4_r;
      vql_r[0] <= vc2_r;
      for (int k = 1; k < ML; k++) begin
        vl_r[k]  <= vl_r[k-1];
        vql_r[k] <= vql_r[k-1];
      end
      v7_r  <= vl_r[ML-1];
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      vc1_r <= vd;
      vc2_r <= vc1_r;
      vs_r  <= vql_r[ML-1];
    end
  end

  ssd_sqrt #(.SW(SW), .OW(C)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vs_r),
    .sum_i  (sum_r),
    .vld_o  (out_valid),
    .dist_o (out_closest_distance)
  );

endmodule
